FILE: rtl/cts_pkg.sv
`timescale 1ns / 1ps

package cts_pkg;

	localparam int SUFFIX_DEPTH = 16;
	localparam int SUF_IDX_W = (SUFFIX_DEPTH > 1) ? $clog2(SUFFIX_DEPTH) : 1;
	localparam int SUF_CNT_W = $clog2(SUFFIX_DEPTH + 1);
	localparam int KEY_W = 4;
	localparam int CHART_LEN = 12;

	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SHARP = 8'h23;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_B = 8'h42;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_H = 8'h48;

	typedef enum logic [1:0] {
		KIND_CHAR,
		KIND_EOL,
		KIND_SONG,
		KIND_RSVD
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_ROOT_ERR,
		ST_OVERFLOW
	} status_t;

	typedef enum logic [1:0] {
		MODE_OUTSIDE,
		MODE_ROOT,
		MODE_SHARP,
		MODE_SUFFIX
	} mode_t;

	// what the held item does, worked out from the item and parser state
	typedef enum logic [3:0] {
		CL_IGNORE,
		CL_NEWSONG,
		CL_LINE,
		CL_COPY,
		CL_CLOSE,
		CL_ERR_ROOT,
		CL_ERR_OVF,
		CL_ROOT,
		CL_SHARP,
		CL_SUFFIX
	} cls_t;

	typedef enum logic [2:0] {
		EM_SINGLE,
		EM_ROOT,
		EM_SHARP,
		EM_SUFFIX,
		EM_TERM
	} emit_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_code;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       line_end;
		logic       last;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		logic  capture;
		logic  commit;
		logic  emit;
		emit_t emit_sel;
		logic  suf_next;
		logic  term_done;
	} cmd_t;

	typedef struct packed {
		cls_t cls;
		logic slot_free;
		logic pos_sharp;
		logic suf_empty;
		logic suf_last;
	} stat_t;

	typedef struct packed {
		logic             hit;
		logic [KEY_W-1:0] idx;
	} chart_hit_t;

	function automatic logic [7:0] chart_letter(input logic [KEY_W-1:0] pos);
		logic [7:0] l;
		case (pos)
			4'd0: l = CH_A;
			4'd1: l = CH_B;
			4'd2: l = CH_H;
			4'd3, 4'd4: l = CH_C;
			4'd5, 4'd6: l = CH_D;
			4'd7: l = CH_E;
			4'd8, 4'd9: l = CH_F;
			4'd10, 4'd11: l = CH_G;
			default: l = CH_A;
		endcase
		return l;
	endfunction

	function automatic logic chart_is_sharp(input logic [KEY_W-1:0] pos);
		logic s;
		case (pos)
			4'd4, 4'd6, 4'd9, 4'd11: s = 1'b1;
			default: s = 1'b0;
		endcase
		return s;
	endfunction

	function automatic chart_hit_t chart_lookup(input logic [7:0] letter, input logic sharp);
		chart_hit_t h;
		h.hit = 1'b1;
		h.idx = '0;
		case (letter)
			CH_A: begin
				h.hit = !sharp;
				h.idx = 4'd0;
			end
			CH_B: begin
				h.hit = !sharp;
				h.idx = 4'd1;
			end
			CH_H: begin
				h.hit = !sharp;
				h.idx = 4'd2;
			end
			CH_C: h.idx = sharp ? 4'd4 : 4'd3;
			CH_D: h.idx = sharp ? 4'd6 : 4'd5;
			CH_E: begin
				h.hit = !sharp;
				h.idx = 4'd7;
			end
			CH_F: h.idx = sharp ? 4'd9 : 4'd8;
			CH_G: h.idx = sharp ? 4'd11 : 4'd10;
			default: h.hit = 1'b0;
		endcase
		return h;
	endfunction

endpackage

FILE: rtl/cts_ctrl.sv
`timescale 1ns / 1ps

module cts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  cts_pkg::stat_t stat,
	output cts_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_ROOT,
		S_SHARP,
		S_SUFFIX,
		S_TERM
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.emit_sel = cts_pkg::EM_SINGLE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (stat.cls)
					cts_pkg::CL_LINE, cts_pkg::CL_COPY,
					cts_pkg::CL_ERR_ROOT, cts_pkg::CL_ERR_OVF: begin
						if (stat.slot_free) begin
							cmd.commit = 1'b1;
							cmd.emit = 1'b1;
							state_d = S_IDLE;
						end
					end
					cts_pkg::CL_CLOSE: begin
						cmd.commit = 1'b1;
						state_d = S_ROOT;
					end
					default: begin
						cmd.commit = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_ROOT: begin
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = cts_pkg::EM_ROOT;
					if (stat.pos_sharp)
						state_d = S_SHARP;
					else if (stat.suf_empty)
						state_d = S_TERM;
					else
						state_d = S_SUFFIX;
				end
			end
			S_SHARP: begin
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = cts_pkg::EM_SHARP;
					state_d = stat.suf_empty ? S_TERM : S_SUFFIX;
				end
			end
			S_SUFFIX: begin
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = cts_pkg::EM_SUFFIX;
					cmd.suf_next = 1'b1;
					if (stat.suf_last)
						state_d = S_TERM;
				end
			end
			S_TERM: begin
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = cts_pkg::EM_TERM;
					cmd.term_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: rtl/cts_dp.sv
`timescale 1ns / 1ps

module cts_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cts_pkg::cmd_t             cmd,
	input  cts_pkg::item_t            item,
	input  logic                      res_ready,
	output logic                      res_valid,
	output cts_pkg::res_t             res,
	input  logic                      cfg_we,
	input  logic [cts_pkg::KEY_W-1:0] cfg_wdata,
	output logic [cts_pkg::KEY_W-1:0] target_key,
	output cts_pkg::stat_t            stat
);

	localparam int KW = cts_pkg::KEY_W;
	localparam int CW = cts_pkg::SUF_CNT_W;
	localparam int IW = cts_pkg::SUF_IDX_W;

	cts_pkg::item_t  item_q;
	logic [KW-1:0]   target_q;
	cts_pkg::mode_t  mode_q;
	logic [7:0]      letter_q;
	logic            sharp_q;
	logic [7:0]      store_q [cts_pkg::SUFFIX_DEPTH];
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   k_q;
	logic [KW-1:0]   shift_q;
	logic            known_q;
	logic            pt_q;
	logic            err_q;
	logic [KW-1:0]   pos_q;
	logic            res_valid_q;
	cts_pkg::res_t   res_q;

	cts_pkg::cls_t      cls;
	cts_pkg::chart_hit_t hit;
	logic [7:0]      c;
	logic            is_term;
	logic [KW:0]     shift_sum;
	logic [KW-1:0]   shift_new;
	logic [KW-1:0]   shift_use;
	logic [KW:0]     pos_sum;
	logic [KW-1:0]   pos_new;
	logic [CW-1:0]   k_inc;
	cts_pkg::res_t   res_d;

	assign c = item_q.char_code;
	assign is_term = (c == cts_pkg::CH_CLOSE) || (c == cts_pkg::CH_SLASH);
	assign hit = cts_pkg::chart_lookup(letter_q, sharp_q);

	always_comb begin
		if (item_q.kind == cts_pkg::KIND_SONG)
			cls = cts_pkg::CL_NEWSONG;
		else if (item_q.kind == cts_pkg::KIND_RSVD || err_q)
			cls = cts_pkg::CL_IGNORE;
		else if (item_q.kind == cts_pkg::KIND_EOL)
			cls = cts_pkg::CL_LINE;
		else if (pt_q || mode_q == cts_pkg::MODE_OUTSIDE)
			cls = cts_pkg::CL_COPY;
		else if (is_term) begin
			if (mode_q == cts_pkg::MODE_ROOT || !hit.hit
				|| (!known_q && target_q > KW'(cts_pkg::CHART_LEN - 1)))
				cls = cts_pkg::CL_ERR_ROOT;
			else
				cls = cts_pkg::CL_CLOSE;
		end else if (mode_q == cts_pkg::MODE_ROOT)
			cls = cts_pkg::CL_ROOT;
		else if (mode_q == cts_pkg::MODE_SHARP && c == cts_pkg::CH_SHARP)
			cls = cts_pkg::CL_SHARP;
		else if (count_q >= CW'(cts_pkg::SUFFIX_DEPTH))
			cls = cts_pkg::CL_ERR_OVF;
		else
			cls = cts_pkg::CL_SUFFIX;
	end

	// shift = target - root mod 12 (target already known to be in the chart), then new root position = root + shift mod 12
	always_comb begin
		shift_sum = {1'b0, target_q} + (KW+1)'(cts_pkg::CHART_LEN) - {1'b0, hit.idx};
		if (shift_sum >= (KW+1)'(cts_pkg::CHART_LEN))
			shift_new = KW'(shift_sum - (KW+1)'(cts_pkg::CHART_LEN));
		else
			shift_new = shift_sum[KW-1:0];
		shift_use = known_q ? shift_q : shift_new;
		pos_sum = {1'b0, hit.idx} + {1'b0, shift_use};
		if (pos_sum >= (KW+1)'(cts_pkg::CHART_LEN))
			pos_new = KW'(pos_sum - (KW+1)'(cts_pkg::CHART_LEN));
		else
			pos_new = pos_sum[KW-1:0];
	end

	assign k_inc = k_q + CW'(1);

	always_comb begin
		res_d = '0;
		case (cmd.emit_sel)
			cts_pkg::EM_SINGLE: begin
				res_d.last = 1'b1;
				case (cls)
					cts_pkg::CL_LINE: res_d.line_end = 1'b1;
					cts_pkg::CL_COPY: res_d.out_char = c;
					cts_pkg::CL_ERR_ROOT: res_d.status = cts_pkg::ST_ROOT_ERR;
					cts_pkg::CL_ERR_OVF: res_d.status = cts_pkg::ST_OVERFLOW;
					default: res_d.status = cts_pkg::ST_OK;
				endcase
			end
			cts_pkg::EM_ROOT: res_d.out_char = cts_pkg::chart_letter(pos_q);
			cts_pkg::EM_SHARP: res_d.out_char = cts_pkg::CH_SHARP;
			cts_pkg::EM_SUFFIX: res_d.out_char = store_q[k_q[IW-1:0]];
			cts_pkg::EM_TERM: begin
				res_d.out_char = c;
				res_d.last = 1'b1;
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= item;
		if (cmd.commit && cls == cts_pkg::CL_CLOSE)
			pos_q <= pos_new;
		if (cmd.commit && cls == cts_pkg::CL_SUFFIX)
			store_q[count_q[IW-1:0]] <= c;
		if (cmd.emit)
			res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			mode_q <= cts_pkg::MODE_OUTSIDE;
			letter_q <= '0;
			sharp_q <= 1'b0;
			count_q <= '0;
			k_q <= '0;
			shift_q <= '0;
			known_q <= 1'b0;
			pt_q <= 1'b0;
			err_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				target_q <= cfg_wdata;
			if (cmd.emit)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			if (cmd.suf_next)
				k_q <= k_inc;
			if (cmd.term_done)
				count_q <= '0;
			if (cmd.commit) begin
				k_q <= '0;
				case (cls)
					cts_pkg::CL_NEWSONG: begin
						shift_q <= '0;
						known_q <= 1'b0;
						pt_q <= 1'b0;
						err_q <= 1'b0;
						mode_q <= cts_pkg::MODE_OUTSIDE;
						count_q <= '0;
					end
					cts_pkg::CL_LINE: begin
						mode_q <= cts_pkg::MODE_OUTSIDE;
						count_q <= '0;
					end
					cts_pkg::CL_COPY: begin
						if (!pt_q && c == cts_pkg::CH_OPEN)
							mode_q <= cts_pkg::MODE_ROOT;
					end
					cts_pkg::CL_CLOSE: begin
						if (!known_q) begin
							shift_q <= shift_new;
							known_q <= 1'b1;
							pt_q <= (shift_new == '0);
						end
						mode_q <= (c == cts_pkg::CH_SLASH) ? cts_pkg::MODE_ROOT
							: cts_pkg::MODE_OUTSIDE;
					end
					cts_pkg::CL_ERR_ROOT, cts_pkg::CL_ERR_OVF: begin
						err_q <= 1'b1;
						mode_q <= cts_pkg::MODE_OUTSIDE;
						count_q <= '0;
					end
					cts_pkg::CL_ROOT: begin
						letter_q <= c;
						sharp_q <= 1'b0;
						mode_q <= cts_pkg::MODE_SHARP;
					end
					cts_pkg::CL_SHARP: begin
						sharp_q <= 1'b1;
						mode_q <= cts_pkg::MODE_SUFFIX;
					end
					cts_pkg::CL_SUFFIX: begin
						mode_q <= cts_pkg::MODE_SUFFIX;
						count_q <= count_q + CW'(1);
					end
					default: mode_q <= mode_q;
				endcase
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;
	assign target_key = target_q;

	assign stat.cls = cls;
	assign stat.slot_free = !res_valid_q || res_ready;
	assign stat.pos_sharp = cts_pkg::chart_is_sharp(pos_q);
	assign stat.suf_empty = (count_q == '0);
	assign stat.suf_last = (k_inc == count_q);

endmodule

FILE: rtl/chord_transposer_stream_top.sv
`timescale 1ns / 1ps

// channel  | direction | handshake               | payload
// item     | in        | item_valid / item_ready | item  (kind, char_code)
// res      | out       | res_valid / res_ready   | res   (out_char, line_end, last, status)
// config   | in        | apb psel/penable/pwrite | target_key at byte address 0
//
// every item is first transferred, then classified in a decide step that also
// updates the parser; a chord close then sends its results one after another
// (root, optional sharp, each buffered suffix byte, terminator), since the
// output register holds one result at a time
// reset is asynchronous and active low; the suffix buffer is not cleared
// a stalled result holds the sequencer; the next item transfer waits for idle

module chord_transposer_stream_top (
	input  logic           clk,
	input  logic           arst_n,
	// configuration port
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	// input text stream
	input  logic           item_valid,
	output logic           item_ready,
	input  cts_pkg::item_t item,
	// output text stream
	output logic           res_valid,
	input  logic           res_ready,
	output cts_pkg::res_t  res
);

	cts_pkg::cmd_t               cmd;
	cts_pkg::stat_t              stat;
	logic                        cfg_we;
	logic [cts_pkg::KEY_W-1:0]   target_key;

	// one register, word aligned at address zero
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {{(32 - cts_pkg::KEY_W){1'b0}}, target_key};

	// sequencer: accepts, classifies and walks the chord burst
	cts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// parser state, suffix buffer, transposition and output register
	cts_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item       (item),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_wdata  (pwdata[cts_pkg::KEY_W-1:0]),
		.target_key (target_key),
		.stat       (stat)
	);

`ifndef SYNTH
	// one item in flight: no transfer right after another
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while previous still in work");

	// a burst that is not finished keeps the input closed
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> !item_ready)
		else $error("input reopened in the middle of a chord burst");

	// error and line end results stand alone
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.line_end || res.status != cts_pkg::ST_OK)
		|-> res.last && res.out_char == 8'd0)
		else $error("status or line end result malformed");
`endif

endmodule
